>>> sv/stq_pkg.sv
// Package for the software timer queue: entry, scan carry and control types.
// Used by stq_cell and software_timer_queue; depends on nothing.

package stq_pkg;

    localparam int ID_W = 8;

    typedef enum logic [1:0] {
        OP_POLL  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        EV_DONE     = 2'd0,
        EV_EXPIRED  = 2'd1,
        EV_INACTIVE = 2'd2,
        EV_NOTHING  = 2'd3
    } event_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AGE,
        S_SCAN,
        S_DECIDE,
        S_CORR,
        S_EXPIRE,
        S_INSERT,
        S_RESULT,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_AGE,
        CELL_REMOVE,
        CELL_INSERT,
        CELL_EXPUPD,
        CELL_SCAN_POLL,
        CELL_SCAN_MATCH
    } cell_op_t;

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
        logic [31:0]     rem;
        logic [31:0]     rld;
        logic [31:0]     expc;
        logic [7:0]      prio;
    } entry_t;

    typedef struct packed {
        logic            alive;
        logic            found;
        logic [ID_W-1:0] pos;
        entry_t          ent;
    } carry_t;

    typedef struct packed {
        cell_op_t        op;
        logic [31:0]     diff;
        logic [ID_W-1:0] pos;
        logic [31:0]     expv;
        entry_t          ins;
    } cell_ctrl_t;

endpackage

>>> sv/stq_cell.sv
// One position of the deadline-ordered timer chain, with its scan carry stage.
// Depends on stq_pkg.

module stq_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  stq_pkg::cell_ctrl_t       ctrl,
    input  logic [stq_pkg::ID_W-1:0]  cell_idx,
    input  stq_pkg::entry_t           left,
    input  stq_pkg::entry_t           right,
    input  stq_pkg::carry_t           carry_in,
    output stq_pkg::entry_t           ent,
    output stq_pkg::carry_t           carry_out
);
    import stq_pkg::*;

    entry_t ent_reg;
    entry_t ent_next;
    carry_t carry_reg;
    carry_t carry_next;
    logic   mine_gt;
    logic   left_gt;
    logic   alive;
    logic   take;
    logic   hit;

    always_comb
    begin
        ent_next   = ent_reg;
        carry_next = carry_reg;
        mine_gt    = !ent_reg.valid || (ent_reg.rem > ctrl.ins.rem);
        left_gt    = !left.valid || (left.rem > ctrl.ins.rem);
        alive      = carry_in.alive && ent_reg.valid && (ent_reg.rem == 32'd0);
        take       = alive && (!carry_in.found || (ent_reg.prio < carry_in.ent.prio));
        hit        = !carry_in.found && ent_reg.valid && (ent_reg.id == ctrl.ins.id);
        case (ctrl.op)
            CELL_AGE:
            begin
                ent_next.rem = (ent_reg.rem >= ctrl.diff) ? ent_reg.rem - ctrl.diff : 32'd0;
            end
            CELL_REMOVE:
            begin
                if (cell_idx >= ctrl.pos)
                begin
                    ent_next = right;
                end
            end
            CELL_INSERT:
            begin
                if (mine_gt)
                begin
                    ent_next = left_gt ? left : ctrl.ins;
                end
            end
            CELL_EXPUPD:
            begin
                if (cell_idx == ctrl.pos)
                begin
                    ent_next.expc = ctrl.expv;
                end
            end
            CELL_SCAN_POLL:
            begin
                carry_next.alive = alive;
                carry_next.found = carry_in.found || take;
                carry_next.pos   = take ? cell_idx : carry_in.pos;
                carry_next.ent   = take ? ent_reg : carry_in.ent;
            end
            CELL_SCAN_MATCH:
            begin
                carry_next.alive = 1'b0;
                carry_next.found = carry_in.found || hit;
                carry_next.pos   = hit ? cell_idx : carry_in.pos;
                carry_next.ent   = hit ? ent_reg : carry_in.ent;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg   <= '0;
            carry_reg <= '0;
        end
        else
        begin
            ent_reg   <= ent_next;
            carry_reg <= carry_next;
        end
    end

    assign ent       = ent_reg;
    assign carry_out = carry_reg;

endmodule

>>> sv/software_timer_queue.sv
// Software timer queue top level: command sequencer over a chain of timer cells.
// Depends on stq_pkg and stq_cell.
//
// A command is taken when start is high and busy is low. Busy falls at the same edge that
// puts the transaction's final result, marked by last, on the result ports, so that result
// is shown in the first cycle with busy low. Results appear for one cycle each with strobe
// high and cannot be held off. Every poll, start or stop that is carried out first ages the
// chain and then runs a scan that travels one cell per cycle along all SLOTS cells. A stop
// then decides and finishes; a start then decides, inserts the timer when it is queued, shows
// its result and finishes. A poll, after ageing, reports an expiry for each scan that finds
// a timer due (then corrects, expires, and inserts again when a periodic timer is queued
// again), then runs a scan that finds nothing more due; once MAX_EXPIRED expiries have been
// reported that scan is dropped and the poll finishes. A poll that finds nothing due ages,
// scans once and finishes. Commands that change nothing (disabled poll, bad slot, unused
// opcode) go straight to the finish step.

module software_timer_queue #(
    parameter int SLOTS       = 16,
    parameter int MAX_EXPIRED = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic [1:0]  opcode,
    input  logic [31:0] now,
    input  logic [3:0]  slot,
    input  logic [31:0] timeout,
    input  logic [31:0] period,
    input  logic [7:0]  priority_req,
    output logic        strobe,
    output logic [1:0]  event_res,
    output logic [3:0]  slot_res,
    output logic        last
);
    import stq_pkg::*;

    localparam int CW = $clog2(SLOTS);
    localparam int NW = $clog2(MAX_EXPIRED + 1);

    state_t          state_reg;
    state_t          state_next;
    logic            enable_reg;
    logic [1:0]      op_reg;
    logic [31:0]     now_reg;
    logic [3:0]      slot_reg;
    logic [31:0]     tmo_reg;
    logic [31:0]     per_reg;
    logic [7:0]      pr_reg;
    logic [31:0]     last_update_reg;
    logic [31:0]     last_update_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;
    logic [NW-1:0]   nres_reg;
    logic [NW-1:0]   nres_next;
    logic [ID_W-1:0] pos_reg;
    logic [ID_W-1:0] pos_next;
    entry_t          pick_reg;
    entry_t          pick_next;
    logic [31:0]     corr_reg;
    logic [31:0]     corr_next;
    logic [31:0]     expn_reg;
    logic [31:0]     expn_next;
    entry_t          ins_reg;
    entry_t          ins_next;
    logic            pend_valid_reg;
    logic [1:0]      pend_ev_reg;
    logic [3:0]      pend_slot_reg;
    logic            out_strobe_reg;
    logic [1:0]      out_ev_reg;
    logic [3:0]      out_slot_reg;
    logic            out_last_reg;

    logic            push;
    logic [1:0]      push_ev;
    logic [3:0]      push_slot;
    logic            finish;
    cell_ctrl_t      ctrl;
    carry_t          fc;
    carry_t          carry_init;
    entry_t          edge_left;
    entry_t          edge_right;
    logic            accept;
    logic            stay;
    logic [32:0]     tsub;
    logic [31:0]     tsat;
    logic [31:0]     start_exp;
    logic [31:0]     start_dist;

    entry_t ents   [SLOTS];
    carry_t carries[SLOTS];

    assign accept   = start && !busy;
    assign busy     = (state_reg != S_IDLE);
    assign fc       = carries[SLOTS-1];

    always_comb
    begin
        carry_init       = '0;
        carry_init.alive = 1'b1;
        edge_left        = '0;
        edge_left.valid  = 1'b1;
        edge_right       = '0;
    end

    assign stay = (pick_reg.rld != 32'd0) && !corr_reg[31] && (corr_reg >= pick_reg.rld);
    assign tsub = {1'b0, pick_reg.rld} - {corr_reg[31], corr_reg};
    assign tsat = tsub[32] ? 32'hFFFF_FFFF : tsub[31:0];
    assign start_exp  = now_reg + ((per_reg != 32'd0) ? per_reg : tmo_reg);
    assign start_dist = (tmo_reg != 32'd0) ? tmo_reg : per_reg;

    generate
        for (genvar i = 0; i < SLOTS; i++)
        begin : g_cell
            entry_t lft;
            entry_t rgt;
            carry_t cin;
            if (i == 0)
            begin : g_first
                assign lft = edge_left;
                assign cin = carry_init;
            end
            else
            begin : g_mid
                assign lft = ents[i-1];
                assign cin = carries[i-1];
            end
            if (i == SLOTS - 1)
            begin : g_end
                assign rgt = edge_right;
            end
            else
            begin : g_inner
                assign rgt = ents[i+1];
            end
            stq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .cell_idx  (ID_W'(i)),
                .left      (lft),
                .right     (rgt),
                .carry_in  (cin),
                .ent       (ents[i]),
                .carry_out (carries[i])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_POLL:  state_next = enable_reg ? S_AGE : S_FINISH;
                        OP_START,
                        OP_STOP:  state_next = ({28'd0, slot} >= 32'(SLOTS)) ? S_FINISH : S_AGE;
                        default:  state_next = S_FINISH;
                    endcase
                end
            end
            S_AGE:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (cnt_reg == CW'(SLOTS - 1))
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (op_reg == OP_POLL)
                begin
                    state_next = fc.found ? S_CORR : S_FINISH;
                end
                else if (op_reg == OP_STOP)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = (start_dist != 32'd0) ? S_INSERT : S_RESULT;
                end
            end
            S_CORR:
            begin
                state_next = S_EXPIRE;
            end
            S_EXPIRE:
            begin
                if (!stay && pick_reg.rld != 32'd0)
                begin
                    state_next = S_INSERT;
                end
                else if (32'(nres_reg) + 32'd1 < 32'(MAX_EXPIRED))
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_INSERT:
            begin
                if (op_reg != OP_POLL)
                begin
                    state_next = S_RESULT;
                end
                else if (32'(nres_reg) < 32'(MAX_EXPIRED))
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_RESULT:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        push             = 1'b0;
        push_ev          = EV_DONE;
        push_slot        = 4'd0;
        finish           = 1'b0;
        ctrl             = '0;
        ctrl.op          = CELL_HOLD;
        ctrl.ins         = ins_reg;
        ctrl.pos         = pos_reg;
        ctrl.expv        = expn_reg;
        ctrl.diff        = now_reg - last_update_reg;
        last_update_next = last_update_reg;
        cnt_next         = cnt_reg;
        nres_next        = nres_reg;
        pos_next         = pos_reg;
        pick_next        = pick_reg;
        corr_next        = corr_reg;
        expn_next        = expn_reg;
        ins_next         = ins_reg;
        case (state_reg)
            S_IDLE:
            begin
                nres_next = '0;
                if (accept)
                begin
                    case (opcode)
                        OP_POLL:
                        begin
                            if (!enable_reg)
                            begin
                                push    = 1'b1;
                                push_ev = EV_NOTHING;
                            end
                        end
                        OP_START,
                        OP_STOP:
                        begin
                            if ({28'd0, slot} >= 32'(SLOTS))
                            begin
                                push      = 1'b1;
                                push_ev   = EV_INACTIVE;
                                push_slot = slot;
                            end
                        end
                        default:
                        begin
                            push      = 1'b1;
                            push_ev   = EV_DONE;
                            push_slot = slot;
                        end
                    endcase
                end
            end
            S_AGE:
            begin
                ctrl.op          = CELL_AGE;
                last_update_next = now_reg;
                cnt_next         = '0;
                ins_next.id      = {{(ID_W-4){1'b0}}, slot_reg};
            end
            S_SCAN:
            begin
                ctrl.op  = (op_reg == OP_POLL) ? CELL_SCAN_POLL : CELL_SCAN_MATCH;
                cnt_next = cnt_reg + 1'b1;
            end
            S_DECIDE:
            begin
                pos_next  = fc.pos;
                pick_next = fc.ent;
                ctrl.pos  = fc.pos;
                if (op_reg == OP_POLL)
                begin
                    if (!fc.found && nres_reg == '0)
                    begin
                        push    = 1'b1;
                        push_ev = EV_NOTHING;
                    end
                end
                else
                begin
                    if (fc.found)
                    begin
                        ctrl.op = CELL_REMOVE;
                    end
                    if (op_reg == OP_STOP)
                    begin
                        push      = 1'b1;
                        push_ev   = fc.found ? EV_DONE : EV_INACTIVE;
                        push_slot = slot_reg;
                    end
                    else
                    begin
                        ins_next.valid = 1'b1;
                        ins_next.id    = {{(ID_W-4){1'b0}}, slot_reg};
                        ins_next.rem   = start_dist;
                        ins_next.rld   = per_reg;
                        ins_next.expc  = start_exp;
                        ins_next.prio  = pr_reg;
                        if (tmo_reg == 32'd0)
                        begin
                            push      = 1'b1;
                            push_ev   = EV_EXPIRED;
                            push_slot = slot_reg;
                        end
                    end
                end
            end
            S_CORR:
            begin
                corr_next = now_reg - pick_reg.expc;
                expn_next = pick_reg.expc + pick_reg.rld;
            end
            S_EXPIRE:
            begin
                push      = 1'b1;
                push_ev   = EV_EXPIRED;
                push_slot = pick_reg.id[3:0];
                nres_next = nres_reg + 1'b1;
                cnt_next  = '0;
                if (stay)
                begin
                    ctrl.op = CELL_EXPUPD;
                end
                else
                begin
                    ctrl.op        = CELL_REMOVE;
                    ins_next       = pick_reg;
                    ins_next.valid = 1'b1;
                    ins_next.rem   = tsat;
                    ins_next.expc  = expn_reg;
                end
            end
            S_INSERT:
            begin
                ctrl.op  = CELL_INSERT;
                cnt_next = '0;
            end
            S_RESULT:
            begin
                push      = 1'b1;
                push_ev   = EV_DONE;
                push_slot = slot_reg;
            end
            S_FINISH:
            begin
                finish = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            enable_reg      <= 1'b0;
            last_update_reg <= 32'd0;
            cnt_reg         <= '0;
            nres_reg        <= '0;
            pend_valid_reg  <= 1'b0;
            out_strobe_reg  <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            last_update_reg <= last_update_next;
            cnt_reg         <= cnt_next;
            nres_reg        <= nres_next;
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
            end
            out_strobe_reg <= 1'b0;
            out_last_reg   <= 1'b0;
            if (push)
            begin
                pend_valid_reg <= 1'b1;
                out_strobe_reg <= pend_valid_reg;
            end
            else if (finish)
            begin
                pend_valid_reg <= 1'b0;
                out_strobe_reg <= pend_valid_reg;
                out_last_reg   <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            now_reg  <= now;
            slot_reg <= slot;
            tmo_reg  <= timeout;
            per_reg  <= period;
            pr_reg   <= priority_req;
        end
        pos_reg  <= pos_next;
        pick_reg <= pick_next;
        corr_reg <= corr_next;
        expn_reg <= expn_next;
        ins_reg  <= ins_next;
        if (push)
        begin
            pend_ev_reg   <= push_ev;
            pend_slot_reg <= push_slot;
        end
        if (push || finish)
        begin
            out_ev_reg   <= pend_ev_reg;
            out_slot_reg <= pend_slot_reg;
        end
    end

    assign strobe    = out_strobe_reg;
    assign event_res = out_ev_reg;
    assign slot_res  = out_slot_reg;
    assign last      = out_last_reg;

`ifndef SYNTHESIS
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> !busy)
        else $error("final result shown while still busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("non-final result shown while idle");
`endif

endmodule
